[src/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg
// Shared widths, defaults and the per-edge record for the point-in-polygon
// test.
// ----------------------------------------------------------------------------
package pip_pkg;

    // Field widths.
    localparam int PNT_W  = 16;
    localparam int VTX_W  = 24;
    localparam int OFS_W  = 8;
    localparam int CNT_W  = 9;
    localparam int DIFF_W = VTX_W + 1;
    localparam int PROD_W = 2 * DIFF_W;

    // Defaults.
    localparam int                 MAX_VERTICES_DEF = 256;
    localparam logic [OFS_W-1:0]   PROBE_OFFSET_RST = 8'd3;

    // One edge, prepared for the final compare. When decided is set the
    // edge outcome is already known and held in dval; otherwise the
    // cross-multiplied products settle it, with up giving the edge direction.
    typedef struct packed {
        logic                     decided;
        logic                     dval;
        logic                     up;
        logic signed [PROD_W-1:0] lhs;
        logic signed [PROD_W-1:0] rhs;
    } edge_pre_t;

endpackage

[src/point_in_polygon_test.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd ray casting over a stream of Q15.8 polygon vertices; one result
// per polygon giving the inside flag and the counted crossings.
//
//   Channel  | Ports                         | Moves
//   ---------+-------------------------------+-------------------------------
//   input    | s_valid / s_ready             | point and one vertex per item
//   result   | m_valid / m_ready             | inside flag, crossing count
//   config   | cfg_valid / cfg_ready         | probe_offset register
//
// One vertex is taken every cycle while the edge register does not stall.
// A vertex passes an input register, an edge register holding the classified
// edges and products, then updates the count (and result register if last).
// Synchronous active-low reset empties all stages and sets the offset to 3.
// Only a last vertex waits on a stalled result register, but it blocks those behind it.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pip_pkg::OFS_W-1:0]         cfg_probe_offset,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [pip_pkg::PNT_W-1:0]  s_point_x,
    input  logic signed [pip_pkg::PNT_W-1:0]  s_point_y,
    input  logic signed [pip_pkg::VTX_W-1:0]  s_vertex_x,
    input  logic signed [pip_pkg::VTX_W-1:0]  s_vertex_y,
    input  logic                              s_last_vertex,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_inside_res,
    output logic [pip_pkg::CNT_W-1:0]         m_crossings
);
    import pip_pkg::*;

    logic [OFS_W-1:0]        ofs_reg;

    // Input register.
    logic                    a_valid_reg;
    logic signed [PNT_W-1:0] a_px_reg, a_py_reg;
    logic signed [VTX_W-1:0] a_vx_reg, a_vy_reg;
    logic                    a_last_reg;

    // Polygon state.
    logic                    awaiting_first_reg;
    logic signed [VTX_W-1:0] first_vx_reg, first_vy_reg;
    logic signed [VTX_W-1:0] prev_vx_reg, prev_vy_reg;
    logic signed [VTX_W-1:0] probe_x_reg, probe_y_reg;

    // Edge register.
    logic                    b_valid_reg;
    logic                    b_first_reg;
    logic                    b_last_reg;
    edge_pre_t               e1_reg, e2_reg;

    edge_pre_t               e1_pre, e2_pre;
    logic                    b_ready;
    logic                    a_adv;
    logic                    s_fire;

    // Configuration register, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ofs_reg <= PROBE_OFFSET_RST;
        end else if (cfg_valid) begin
            ofs_reg <= cfg_probe_offset;
        end
    end

    // Stage handshakes.
    assign a_adv   = a_valid_reg && b_ready;
    assign s_ready = !a_valid_reg || b_ready;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= s_fire || (a_valid_reg && !a_adv);
            b_valid_reg <= a_adv || (b_valid_reg && !b_ready);
        end
    end

    // Input register load on each input transfer.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_px_reg   <= s_point_x;
            a_py_reg   <= s_point_y;
            a_vx_reg   <= s_vertex_x;
            a_vy_reg   <= s_vertex_y;
            a_last_reg <= s_last_vertex;
        end
    end

    // Edge from the previous vertex, and the closing edge to the first vertex.
    pip_edge_math u_edge_prev (
        .probe_x  (probe_x_reg),
        .probe_y  (probe_y_reg),
        .x0       (prev_vx_reg),
        .y0       (prev_vy_reg),
        .x1       (a_vx_reg),
        .y1       (a_vy_reg),
        .edge_pre (e1_pre)
    );

    pip_edge_math u_edge_close (
        .probe_x  (probe_x_reg),
        .probe_y  (probe_y_reg),
        .x0       (a_vx_reg),
        .y0       (a_vy_reg),
        .x1       (first_vx_reg),
        .y1       (first_vy_reg),
        .edge_pre (e2_pre)
    );

    // Polygon state advances as a vertex leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_first_reg <= 1'b1;
            first_vx_reg       <= '0;
            first_vy_reg       <= '0;
            prev_vx_reg        <= '0;
            prev_vy_reg        <= '0;
            probe_x_reg        <= '0;
            probe_y_reg        <= '0;
        end else if (a_adv) begin
            if (awaiting_first_reg) begin
                probe_x_reg  <= {a_px_reg, ofs_reg};
                probe_y_reg  <= {a_py_reg, ofs_reg};
                first_vx_reg <= a_vx_reg;
                first_vy_reg <= a_vy_reg;
            end
            prev_vx_reg        <= a_vx_reg;
            prev_vy_reg        <= a_vy_reg;
            awaiting_first_reg <= a_last_reg;
        end
    end

    // Edge register. A first vertex has no previous edge and its closing edge
    // is a single point, so both are forced to not counted.
    always_ff @(posedge aclk) begin
        if (a_adv) begin
            b_first_reg <= awaiting_first_reg;
            b_last_reg  <= a_last_reg;
            if (awaiting_first_reg) begin
                e1_reg <= '{decided: 1'b1, dval: 1'b0, up: 1'b0, lhs: '0, rhs: '0};
                e2_reg <= '{decided: 1'b1, dval: 1'b0, up: 1'b0, lhs: '0, rhs: '0};
            end else begin
                e1_reg <= e1_pre;
                e2_reg <= a_last_reg ? e2_pre
                        : edge_pre_t'{decided: 1'b1, dval: 1'b0, up: 1'b0,
                                      lhs: '0, rhs: '0};
            end
        end
    end

    // Count, parity and result register.
    pip_tally #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_tally (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .b_valid      (b_valid_reg),
        .b_first      (b_first_reg),
        .b_last       (b_last_reg),
        .e1           (e1_reg),
        .e2           (e2_reg),
        .b_ready      (b_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_inside_res (m_inside_res),
        .m_crossings  (m_crossings)
    );

endmodule

[src/pip_edge_math.sv]
// ----------------------------------------------------------------------------
// pip_edge_math
// Classifies one polygon edge against the probe height and forms the two
// cross-multiplied products for the crossing test.
// ----------------------------------------------------------------------------
module pip_edge_math (
    input  logic signed [pip_pkg::VTX_W-1:0] probe_x,
    input  logic signed [pip_pkg::VTX_W-1:0] probe_y,
    input  logic signed [pip_pkg::VTX_W-1:0] x0,
    input  logic signed [pip_pkg::VTX_W-1:0] y0,
    input  logic signed [pip_pkg::VTX_W-1:0] x1,
    input  logic signed [pip_pkg::VTX_W-1:0] y1,
    output pip_pkg::edge_pre_t               edge_pre
);
    import pip_pkg::*;

    logic signed [VTX_W-1:0]  lo;
    logic signed [VTX_W-1:0]  hi;
    logic                     horiz;
    logic                     outside;
    logic signed [DIFF_W-1:0] dyp;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dxp;
    logic signed [DIFF_W-1:0] dy;

    // Vertical extent of the edge relative to the probe.
    assign hi      = (y0 > y1) ? y0 : y1;
    assign lo      = (y0 < y1) ? y0 : y1;
    assign horiz   = (y0 == y1);
    assign outside = (lo > probe_y) || (hi < probe_y);

    // Differences for the cross-multiplied crossing test.
    assign dyp = DIFF_W'(probe_y) - DIFF_W'(y0);
    assign dx  = DIFF_W'(x1) - DIFF_W'(x0);
    assign dxp = DIFF_W'(probe_x) - DIFF_W'(x0);
    assign dy  = DIFF_W'(y1) - DIFF_W'(y0);

    // Early outcome: skipped edges, and the endpoint-on-ray rules.
    always_comb begin
        edge_pre.decided = horiz || outside || (hi == probe_y) || (lo == probe_y);
        edge_pre.dval    = !horiz && !outside && (hi == probe_y);
        edge_pre.up      = (y1 > y0);
        edge_pre.lhs     = PROD_W'(dyp) * PROD_W'(dx);
        edge_pre.rhs     = PROD_W'(dxp) * PROD_W'(dy);
    end

endmodule

[src/pip_tally.sv]
// ----------------------------------------------------------------------------
// pip_tally
// Finishes both edge tests of a vertex, keeps the crossing count and
// parity, and holds the result register toward the output channel.
// ----------------------------------------------------------------------------
module pip_tally #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          b_valid,
    input  logic                          b_first,
    input  logic                          b_last,
    input  pip_pkg::edge_pre_t            e1,
    input  pip_pkg::edge_pre_t            e2,
    output logic                          b_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_inside_res,
    output logic [pip_pkg::CNT_W-1:0]     m_crossings
);
    import pip_pkg::*;

    localparam int               CAP   = (MAX_VERTICES > 511) ? 511 : MAX_VERTICES;
    localparam logic [CNT_W:0]   CAP_W = (CNT_W+1)'(CAP);

    logic             c1;
    logic             c2;
    logic             retire;
    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             parity_reg, parity_next;
    logic             m_valid_reg;
    logic             inside_reg;
    logic [CNT_W-1:0] crossings_reg;

    // Final crossing decision for each edge.
    assign c1 = e1.decided ? e1.dval : (e1.up ? (e1.lhs >= e1.rhs) : (e1.lhs <= e1.rhs));
    assign c2 = e2.decided ? e2.dval : (e2.up ? (e2.lhs >= e2.rhs) : (e2.lhs <= e2.rhs));

    // A vertex that closes no polygon always retires; a last vertex needs
    // room in the result register.
    assign b_ready = !b_valid || !b_last || !m_valid_reg || m_ready;
    assign retire  = b_valid && b_ready;

    // Saturating count and true parity; a first vertex restarts both.
    always_comb begin
        sum = {1'b0, (b_first ? '0 : count_reg)} + (CNT_W+1)'(c1) + (CNT_W+1)'(c2);
        count_next  = (sum > CAP_W) ? CAP_W[CNT_W-1:0] : sum[CNT_W-1:0];
        parity_next = (b_first ? 1'b0 : parity_reg) ^ c1 ^ c2;
    end

    // Tally state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            parity_reg <= 1'b0;
        end else if (retire) begin
            count_reg  <= count_next;
            parity_reg <= parity_next;
        end
    end

    // Result register and its transfer handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (retire && b_last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (retire && b_last) begin
            inside_reg    <= parity_next;
            crossings_reg <= count_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = inside_reg;
    assign m_crossings  = crossings_reg;

endmodule
